// ----- hdl/dqsv_pkg.sv -----
package dqsv_pkg;

  localparam int PERIOD_COUNTS_DEF = 4096;

  localparam int BUS_W     = 16;
  localparam int DUTY_W    = 12;
  localparam int VW        = 52;   // phase voltages, Q.39 with headroom
  localparam int NUM_W     = 47;   // clamped duty numerator, 0 .. bus * 2^31
  localparam int PM1_W     = 16;   // PERIOD_COUNTS-1 fits here over the legal range
  localparam int VDC_SHIFT = 31;   // bus Q8.8 -> Q.39
  localparam int N_PH      = 3;

  localparam logic [DUTY_W-1:0] DUTY_FIELD_MAX = 12'd4095;
  localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

  typedef struct packed {
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
    logic signed [15:0] sine_theta;
    logic signed [15:0] cosine_theta;
    logic [BUS_W-1:0]   bus_volts;
  } dqsv_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              clipped;
  } dqsv_out_t;

  typedef struct packed {
    logic signed [VW-1:0] va;
    logic signed [VW-1:0] vb;
    logic signed [VW-1:0] vc;
    logic [BUS_W-1:0]     bus;
  } dqsv_phase_t;

  typedef struct packed {
    logic valid;
    logic clip;
  } dqsv_ctl_t;

endpackage

// ----- hdl/dq_voltage_to_svpwm_duty_unit.sv -----
// d/q voltage demand to three-phase PWM compare counts (min-max SVPWM).
//
// Input channel: in_item carries volt_d, volt_q (Q8.8), sine_theta,
// cosine_theta (Q1.15) and bus_volts (unsigned Q8.8). A transaction is
// taken on any rising edge with start high and busy low. busy is held low:
// the pipeline has no state shared between items, so a new transaction can
// be started every cycle, back to back.
// Result channel: out_valid strobes for exactly one cycle with out_item
// (duty_a/b/c compare counts and the clipped flag). The receiver cannot
// stall and nothing here waits on it; every started transaction gives one
// result, in order.
// Throughput is one item per cycle; the pipeline depth is set by the
// restoring divider, one quotient bit per stage, in front of the output
// register.
// Reset (rst_n low, synchronous) clears only the stage valid bits, so any
// transactions in flight are dropped and no stray strobe follows.
module dq_voltage_to_svpwm_duty_unit #(
  parameter int PERIOD_COUNTS = dqsv_pkg::PERIOD_COUNTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dqsv_pkg::dqsv_in_t  in_item,
  output logic                out_valid,
  output dqsv_pkg::dqsv_out_t out_item
);
  import dqsv_pkg::*;

  localparam int QW = $clog2(PERIOD_COUNTS);
  localparam int XW = 17;   // holds any quotient up to 16 bits
  // full-duty count the highest phase always lands on
  localparam logic [DUTY_W-1:0] DUTY_TOP =
    (PERIOD_COUNTS - 1 > 4095) ? DUTY_FIELD_MAX : DUTY_W'(PERIOD_COUNTS - 1);

  logic        in_valid;
  logic        ph_valid;
  dqsv_phase_t ph;
  dqsv_ctl_t   dvd_ctl, quo_ctl;
  logic [QW+BUS_W-1:0] dvd [N_PH];
  logic [BUS_W-1:0]    divisor;
  logic [QW-1:0]       quo [N_PH];

  logic [DUTY_W-1:0] duty_nxt [N_PH];
  logic              out_valid_r;
  dqsv_out_t         out_item_r;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  // Park, Clarke: phase voltages in Q.39
  dqsv_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (ph_valid),
    .out_ph    (ph)
  );

  // min-max offset, clamp at zero, scale by PERIOD-1, drop the 2^31
  dqsv_duty #(
    .PERIOD_COUNTS (PERIOD_COUNTS)
  ) u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ph_valid),
    .in_ph    (ph),
    .out_ctl  (dvd_ctl),
    .out_dvd  (dvd),
    .out_div  (divisor)
  );

  // divide by bus voltage, three lanes in lockstep
  dqsv_div #(
    .QW (QW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (dvd_ctl),
    .in_dvd  (dvd),
    .in_div  (divisor),
    .out_ctl (quo_ctl),
    .out_quo (quo)
  );

  // counts wider than the field (long periods) saturate
  always_comb begin
    for (int l = 0; l < N_PH; l++) begin
      duty_nxt[l] = (XW'(quo[l]) > XW'(DUTY_FIELD_MAX)) ? DUTY_FIELD_MAX
                                                        : DUTY_W'(quo[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= quo_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.duty_a  <= duty_nxt[0];
    out_item_r.duty_b  <= duty_nxt[1];
    out_item_r.duty_c  <= duty_nxt[2];
    out_item_r.clipped <= quo_ctl.clip;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_top_phase_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.duty_a == DUTY_TOP) || (out_item.duty_b == DUTY_TOP) ||
                  (out_item.duty_c == DUTY_TOP))
    else $error("no phase at full duty");

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.duty_a <= DUTY_TOP) && (out_item.duty_b <= DUTY_TOP) &&
                  (out_item.duty_c <= DUTY_TOP))
    else $error("duty above full-scale count");

  a_clip_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.clipped) |->
      (out_item.duty_a == '0) || (out_item.duty_b == '0) || (out_item.duty_c == '0))
    else $error("clipped set without a zero duty");

endmodule

// ----- hdl/dqsv_xform.sv -----
module dqsv_xform (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  dqsv_pkg::dqsv_in_t     in_item,
  output logic                   out_valid,
  output dqsv_pkg::dqsv_phase_t  out_ph
);
  import dqsv_pkg::*;

  logic [3:0] v_r;

  // stage 1: Park products
  logic signed [31:0] p_dc_r, p_qs_r, p_ds_r, p_qc_r;
  logic [BUS_W-1:0]   bus1_r, bus2_r, bus3_r;
  logic [BUS_W-1:0]   bus_nxt;

  // stage 2: alpha / beta
  logic signed [32:0] alpha2_r, beta2_r;
  logic signed [32:0] alpha2_nxt, beta2_nxt;

  // stage 3: sqrt3/2 * beta
  logic signed [32:0]   alpha3_r;
  logic signed [VW-1:0] pb3_r, pb3_nxt;

  // stage 4: phase voltages
  logic signed [VW-1:0] va_nxt, vb_nxt, vc_nxt, a15_nxt;
  dqsv_phase_t          ph4_r;

  assign bus_nxt = (in_item.bus_volts == '0) ? BUS_W'(1) : in_item.bus_volts;

  assign alpha2_nxt = 33'(p_dc_r) - 33'(p_qs_r);
  assign beta2_nxt  = 33'(p_ds_r) + 33'(p_qc_r);

  assign pb3_nxt = VW'(beta2_r) * VW'(SQRT3_HALF_Q16);

  assign va_nxt  = VW'(alpha3_r) <<< 16;
  assign a15_nxt = VW'(alpha3_r) <<< 15;
  assign vb_nxt  = pb3_r - a15_nxt;
  assign vc_nxt  = -va_nxt - vb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p_dc_r   <= $signed(in_item.volt_d) * $signed(in_item.cosine_theta);
    p_qs_r   <= $signed(in_item.volt_q) * $signed(in_item.sine_theta);
    p_ds_r   <= $signed(in_item.volt_d) * $signed(in_item.sine_theta);
    p_qc_r   <= $signed(in_item.volt_q) * $signed(in_item.cosine_theta);
    bus1_r   <= bus_nxt;
    alpha2_r <= alpha2_nxt;
    beta2_r  <= beta2_nxt;
    bus2_r   <= bus1_r;
    alpha3_r <= alpha2_r;
    pb3_r    <= pb3_nxt;
    bus3_r   <= bus2_r;
    ph4_r.va  <= va_nxt;
    ph4_r.vb  <= vb_nxt;
    ph4_r.vc  <= vc_nxt;
    ph4_r.bus <= bus3_r;
  end

  assign out_valid = v_r[3];
  assign out_ph    = ph4_r;

endmodule

// ----- hdl/dqsv_duty.sv -----
module dqsv_duty #(
  parameter int PERIOD_COUNTS = dqsv_pkg::PERIOD_COUNTS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_valid,
  input  dqsv_pkg::dqsv_phase_t                              in_ph,
  output dqsv_pkg::dqsv_ctl_t                                out_ctl,
  output logic [$clog2(PERIOD_COUNTS)+dqsv_pkg::BUS_W-1:0]   out_dvd [dqsv_pkg::N_PH],
  output logic [dqsv_pkg::BUS_W-1:0]                         out_div
);
  import dqsv_pkg::*;

  localparam int QW = $clog2(PERIOD_COUNTS);
  localparam int DW = QW + BUS_W;
  localparam int NW = VW + 2;
  localparam int HW = NUM_W - 16 + PM1_W;
  localparam int LW = 16 + PM1_W;
  localparam int SW = HW + 16;
  localparam logic [PM1_W-1:0] PM1 = PM1_W'(PERIOD_COUNTS - 1);

  logic [3:0] v_r;

  // stage 5: highest phase
  dqsv_phase_t          ph5_r;
  logic signed [VW-1:0] vmax5_r, vmax_nxt;

  // stage 6: numerator vdc - (vmax - vx), clamped at zero
  logic signed [VW-1:0] vx5 [N_PH];
  logic signed [NW-1:0] vdc_nxt;
  logic signed [NW-1:0] num_nxt  [N_PH];
  logic [N_PH-1:0]      neg_nxt;
  logic [NUM_W-1:0]     numc_nxt [N_PH];
  logic [NUM_W-1:0]     numc6_r  [N_PH];
  logic                 clip6_r, clip7_r, clip8_r;
  logic [BUS_W-1:0]     bus6_r, bus7_r, bus8_r;

  // stage 7: (PERIOD-1) * numerator as two partial products
  logic [HW-1:0] hi7_r [N_PH];
  logic [LW-1:0] lo7_r [N_PH];

  // stage 8: dividend = product >> 31
  logic [SW-1:0] sum_nxt [N_PH];
  logic [DW-1:0] dvd8_r  [N_PH];

  always_comb begin
    vmax_nxt = in_ph.va;
    if (in_ph.vb > vmax_nxt) vmax_nxt = in_ph.vb;
    if (in_ph.vc > vmax_nxt) vmax_nxt = in_ph.vc;
  end

  assign vx5[0] = ph5_r.va;
  assign vx5[1] = ph5_r.vb;
  assign vx5[2] = ph5_r.vc;

  assign vdc_nxt = $signed({{(NW-BUS_W-VDC_SHIFT){1'b0}}, ph5_r.bus, {VDC_SHIFT{1'b0}}});

  always_comb begin
    for (int l = 0; l < N_PH; l++) begin
      num_nxt[l]  = vdc_nxt - (NW'(vmax5_r) - NW'(vx5[l]));
      neg_nxt[l]  = num_nxt[l][NW-1];
      numc_nxt[l] = neg_nxt[l] ? '0 : num_nxt[l][NUM_W-1:0];
      sum_nxt[l]  = {hi7_r[l], 16'b0} + SW'(lo7_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ph5_r   <= in_ph;
    vmax5_r <= vmax_nxt;
    clip6_r <= |neg_nxt;
    bus6_r  <= ph5_r.bus;
    clip7_r <= clip6_r;
    bus7_r  <= bus6_r;
    clip8_r <= clip7_r;
    bus8_r  <= bus7_r;
    for (int l = 0; l < N_PH; l++) begin
      numc6_r[l] <= numc_nxt[l];
      hi7_r[l]   <= HW'(numc6_r[l][NUM_W-1:16]) * HW'(PM1);
      lo7_r[l]   <= LW'(numc6_r[l][15:0]) * LW'(PM1);
      dvd8_r[l]  <= sum_nxt[l][DW+VDC_SHIFT-1:VDC_SHIFT];
    end
  end

  assign out_ctl.valid = v_r[3];
  assign out_ctl.clip  = clip8_r;
  assign out_dvd       = dvd8_r;
  assign out_div       = bus8_r;

endmodule

// ----- hdl/dqsv_div.sv -----
module dqsv_div #(
  parameter int QW = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dqsv_pkg::dqsv_ctl_t           in_ctl,
  input  logic [QW+dqsv_pkg::BUS_W-1:0] in_dvd [dqsv_pkg::N_PH],
  input  logic [dqsv_pkg::BUS_W-1:0]    in_div,
  output dqsv_pkg::dqsv_ctl_t           out_ctl,
  output logic [QW-1:0]                 out_quo [dqsv_pkg::N_PH]
);
  import dqsv_pkg::*;

  // Restoring division, one quotient bit per stage. Stage 0 holds the
  // upper dividend bits as the partial remainder (already below the
  // divisor); low_r shifts dividend bits out the top and quotient bits in.
  logic [QW:0]      v_r;
  logic             clip_r [0:QW];
  logic [BUS_W-1:0] div_r  [0:QW];
  logic [BUS_W-1:0] rem_r  [0:QW][N_PH];
  logic [QW-1:0]    low_r  [0:QW][N_PH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QW-1:0], in_ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    clip_r[0] <= in_ctl.clip;
    div_r[0]  <= in_div;
    for (int l = 0; l < N_PH; l++) begin
      rem_r[0][l] <= in_dvd[l][QW+BUS_W-1:QW];
      low_r[0][l] <= in_dvd[l][QW-1:0];
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [BUS_W:0]   trial [N_PH];
    logic [N_PH-1:0]  q_nxt;
    logic [BUS_W-1:0] rem_nxt [N_PH];

    always_comb begin
      for (int l = 0; l < N_PH; l++) begin
        trial[l]   = {rem_r[s-1][l], low_r[s-1][l][QW-1]};
        q_nxt[l]   = (trial[l] >= {1'b0, div_r[s-1]});
        rem_nxt[l] = q_nxt[l] ? BUS_W'(trial[l] - {1'b0, div_r[s-1]})
                              : trial[l][BUS_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      clip_r[s] <= clip_r[s-1];
      div_r[s]  <= div_r[s-1];
      for (int l = 0; l < N_PH; l++) begin
        rem_r[s][l] <= rem_nxt[l];
        low_r[s][l] <= {low_r[s-1][l][QW-2:0], q_nxt[l]};
      end
    end
  end

  assign out_ctl.valid = v_r[QW];
  assign out_ctl.clip  = clip_r[QW];
  assign out_quo       = low_r[QW];

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (rem_r[0][0] < div_r[0]) && (rem_r[0][1] < div_r[0]) &&
               (rem_r[0][2] < div_r[0]))
    else $error("initial partial remainder not below divisor");

  a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QW] |-> (rem_r[QW][0] < div_r[QW]) && (rem_r[QW][1] < div_r[QW]) &&
                (rem_r[QW][2] < div_r[QW]))
    else $error("final remainder not below divisor");

  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[QW] && clip_r[QW]) |->
      (low_r[QW][0] == '0) || (low_r[QW][1] == '0) || (low_r[QW][2] == '0))
    else $error("clip flagged but no lane has a zero quotient");

endmodule

// ----- tb/dq_voltage_to_svpwm_duty_unit_tb.sv -----
module dq_voltage_to_svpwm_duty_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsv_pkg::*;

  // PWM period the block is built for; the predictor scales by the same value
  localparam int DUTY_PERIOD = 4096;
  // largest count the duty fields can carry
  localparam longint DUTY_CEIL = (longint'(1) << DUTY_W) - 1;
  // sqrt(3)/2 in Q0.16, the one rounded factor of the inverse Clarke step
  localparam longint ROOT3_OVER_2_Q16 = 56756;
  // final wait after the last phase, comfortably past the start-to-result latency
  localparam int SETTLE_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  dqsv_in_t  in_item;
  logic      out_valid;
  dqsv_out_t out_item;

  // percentage of cycles in which the sender holds off before a transaction
  int sender_idle_pct;

  // Scoreboard: predicts the three compare counts and the clip flag for each
  // accepted demand and checks the strobed results against them in order.
  class duty_scoreboard;
    dqsv_out_t pending_duties[$];
    int        bad_results;

    // one phase: numerator vdc - (vmax - vx), scaled by period-1 over vdc
    function logic [DUTY_W-1:0] phase_duty(longint drop, longint vdc, inout bit clip);
      longint num;
      longint cnt;
      num = vdc - drop;
      if (num < 0) begin
        clip = 1'b1;
        return '0;
      end
      cnt = (longint'(DUTY_PERIOD - 1) * num) / vdc;
      if (cnt > DUTY_CEIL) cnt = DUTY_CEIL;
      return cnt[DUTY_W-1:0];
    endfunction

    function dqsv_out_t predict_duties(dqsv_in_t demand);
      longint    vd, vq, sn, cs, bus;
      longint    alpha, beta, va, vb, vc, vtop, vdc;
      bit        clip;
      dqsv_out_t duties;
      vd  = longint'(signed'(demand.volt_d));
      vq  = longint'(signed'(demand.volt_q));
      sn  = longint'(signed'(demand.sine_theta));
      cs  = longint'(signed'(demand.cosine_theta));
      bus = longint'(demand.bus_volts);
      if (bus == 0) bus = 1;        // zero bus counts as one LSB
      // inverse Park, Q.23
      alpha = vd * cs - vq * sn;
      beta  = vd * sn + vq * cs;
      // inverse Clarke, Q.39
      va = alpha * 65536;
      vb = alpha * (-32768) + beta * ROOT3_OVER_2_Q16;
      vc = -va - vb;
      vtop = va;
      if (vb > vtop) vtop = vb;
      if (vc > vtop) vtop = vc;
      vdc  = bus <<< 31;
      clip = 1'b0;
      duties.duty_a  = phase_duty(vtop - va, vdc, clip);
      duties.duty_b  = phase_duty(vtop - vb, vdc, clip);
      duties.duty_c  = phase_duty(vtop - vc, vdc, clip);
      duties.clipped = clip;
      return duties;
    endfunction

    function void note_demand(dqsv_in_t demand);
      pending_duties.push_back(predict_duties(demand));
    endfunction

    function void check_duties(dqsv_out_t got);
      dqsv_out_t want;
      if (pending_duties.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with no transaction pending: a=%0d b=%0d c=%0d clip=%0b",
                   $time, got.duty_a, got.duty_b, got.duty_c, got.clipped);
        return;
      end
      want = pending_duties.pop_front();
      if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
          got.duty_c !== want.duty_c || got.clipped !== want.clipped) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: duty mismatch: expected a=%0d b=%0d c=%0d clip=%0b, got a=%0d b=%0d c=%0d clip=%0b",
                   $time, want.duty_a, want.duty_b, want.duty_c, want.clipped,
                   got.duty_a, got.duty_b, got.duty_c, got.clipped);
      end
    endfunction

    function int outstanding();
      return pending_duties.size();
    endfunction
  endclass

  duty_scoreboard duty_sb = new();

  dq_voltage_to_svpwm_duty_unit #(
    .PERIOD_COUNTS(DUTY_PERIOD)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: both channels sampled at the edge with pre-edge values, so the
  // accept condition here is the same one the block sees.
  always @(posedge clk) begin
    if (rst_n && start && !busy) duty_sb.note_demand(in_item);
    if (rst_n && out_valid) duty_sb.check_duties(out_item);
  end

  // Generous hard stop.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic dqsv_in_t make_demand(int d, int q, int s, int c, int b);
    dqsv_in_t demand;
    demand.volt_d       = d[15:0];
    demand.volt_q       = q[15:0];
    demand.sine_theta   = s[15:0];
    demand.cosine_theta = c[15:0];
    demand.bus_volts    = b[15:0];
    return demand;
  endfunction

  // corner values for a 16 bit field: both extremes, zero, all ones, one LSB, or a random word
  function automatic int corner_word();
    case ($urandom_range(5))
      0: return 32'h8000;
      1: return 32'h7FFF;
      2: return 0;
      3: return 32'hFFFF;
      4: return 1;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Random demand. Most are plausible operating points: a unit vector for
  // the angle and a voltage sized against the bus, so both the linear and
  // the overmodulated (clipping) regions come up. The rest are raw random
  // words, corner mixes and near-zero bus values.
  function automatic dqsv_in_t random_demand();
    int  kind, bus_v, lim;
    real ang;
    kind = $urandom_range(99);
    if (kind < 55) begin
      bus_v = $urandom_range(65535, 64);
      lim   = bus_v / 2;
      if (lim > 32767) lim = 32767;
      ang = $urandom_range(65535) * 6.283185307 / 65536.0;
      return make_demand(int'($urandom_range(2 * lim)) - lim,
                         int'($urandom_range(2 * lim)) - lim,
                         $rtoi($sin(ang) * 32767.0), $rtoi($cos(ang) * 32767.0), bus_v);
    end else if (kind < 80) begin
      return make_demand($urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535));
    end else if (kind < 95) begin
      return make_demand(corner_word(), corner_word(), corner_word(), corner_word(),
                         corner_word());
    end
    // zero or tiny bus: heavy clipping, and the zero-as-one-LSB rule
    return make_demand($urandom_range(65535), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(65535), $urandom_range(3));
  endfunction

  // Sender: random hold-off, then present the demand and keep start high
  // until the edge that takes it. start is left high for a following
  // transaction, so it gets one assignment per time step.
  task automatic drive_demand(input dqsv_in_t demand);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= demand;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender pauses until every predicted result has been checked.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (duty_sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    repeat (count) drive_demand(random_demand());
    drain_results();
  endtask

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_item         <= '0;
    sender_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero demand, bus extremes (zero bus too), field extremes,
    // the four cardinal angles, a mid-angle, overmodulation, alternating bits
    drive_demand(make_demand(0, 0, 0, 0, 1));
    drive_demand(make_demand(0, 0, 0, 0, 0));
    drive_demand(make_demand(0, 0, 32767, 32767, 65535));
    drive_demand(make_demand(32767, 32767, 32767, 32767, 65535));
    drive_demand(make_demand(-32768, -32768, -32768, -32768, 65535));
    drive_demand(make_demand(-32768, -32768, -32768, -32768, 1));
    drive_demand(make_demand(32767, -32768, -32768, 32767, 0));
    drive_demand(make_demand(0, 12 * 256, 0, 32767, 24 * 256));
    drive_demand(make_demand(0, 12 * 256, 32767, 0, 24 * 256));
    drive_demand(make_demand(0, 12 * 256, 0, -32768, 24 * 256));
    drive_demand(make_demand(0, 12 * 256, -32768, 0, 24 * 256));
    drive_demand(make_demand(-5 * 256, 20 * 256, 23170, 23170, 48 * 256));
    drive_demand(make_demand(3 * 256, -7 * 256, -16384, 28378, 12 * 256));
    drive_demand(make_demand(0, 30 * 256, 0, 32767, 24 * 256));
    drive_demand(make_demand(1, -1, 1, -1, 65535));
    drive_demand(make_demand(-1, -1, -1, -1, 2));
    drive_demand(make_demand(32'h5555, 32'hAAAA, 32'h5555, 32'hAAAA, 32'h5555));
    drive_demand(make_demand(32'hAAAA, 32'h5555, 32'hAAAA, 32'h5555, 32'hAAAA));
    drive_demand(make_demand(127 * 256, 0, 32767, 0, 32'h8000));
    drive_demand(make_demand(0, 0, 32767, 32767, 32'h8000));
    drain_results();

    // random: back to back, sparse sender, back to back again, light gaps
    run_random_phase(0, 370);
    run_random_phase(69, 370);
    run_random_phase(0, 370);
    run_random_phase(26, 370);

    // let any stray strobe show up past the pipeline depth
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (duty_sb.bad_results + duty_sb.outstanding() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
